>>> src/krps_pkg.sv
// Shared types, constants and tables for the kicked rotor phase stepper.
// Used by the register file, controller, datapath and top level; no dependencies.
package krps_pkg;

  localparam int STEP_BITS = 16;
  localparam int CMP_W = (STEP_BITS > 16) ? STEP_BITS : 16;

  localparam logic signed [32:0] CORDIC_K = 33'sd652032874;
  localparam logic signed [23:0] B_Q24 = 24'sd7212011;
  localparam logic [39:0] C_Q43 = 40'd989908258285;
  localparam logic [23:0] FREQ_RESET = 24'd1888100;
  localparam logic [4:0] ROOT_MSB = 5'd20;
  localparam logic [4:0] CORDIC_LAST = 5'd15;
  localparam logic [4:0] DIV_LAST = 5'd23;

  typedef struct packed {
    logic [15:0] kick_one_step;
    logic [15:0] kick_two_step;
    logic [3:0]  kick_one_harmonic;
    logic [3:0]  kick_two_harmonic;
    logic [15:0] kick_one_amplitude;
    logic [15:0] kick_two_amplitude;
    logic [15:0] step_size;
  } cfg_t;

  typedef enum logic [2:0] {
    REG_K1_STEP, REG_K2_STEP, REG_K1_HARM, REG_K2_HARM, REG_K1_AMP, REG_K2_AMP, REG_DT
  } reg_idx_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_KANG, OP_CORDIC, OP_KPROD, OP_KSAT, OP_FMUL, OP_RINIT,
    OP_ROOT, OP_DINIT, OP_DIV, OP_FSET, OP_AMUL, OP_AADD, OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   kick_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic hit_one;
    logic hit_two;
    logic last;
  } dp_stat_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_KANG, S_CORDIC, S_KPROD, S_KSAT, S_FMUL, S_RINIT,
    S_ROOT, S_DINIT, S_DIV, S_FSET, S_AMUL, S_AADD, S_DONE
  } state_t;

  function automatic logic [22:0] atan_turns(input logic [3:0] idx);
    logic [22:0] v;
    case (idx)
      4'd0: v = 23'd2097152;
      4'd1: v = 23'd1238021;
      4'd2: v = 23'd654136;
      4'd3: v = 23'd332050;
      4'd4: v = 23'd166669;
      4'd5: v = 23'd83416;
      4'd6: v = 23'd41718;
      4'd7: v = 23'd20860;
      4'd8: v = 23'd10430;
      4'd9: v = 23'd5215;
      4'd10: v = 23'd2608;
      4'd11: v = 23'd1304;
      4'd12: v = 23'd652;
      4'd13: v = 23'd326;
      4'd14: v = 23'd163;
      4'd15: v = 23'd81;
      default: v = 23'd0;
    endcase
    return v;
  endfunction

endpackage

>>> src/krps_regs.sv
// APB-style configuration registers for the kicked rotor phase stepper.
// Depends on krps_pkg for the register layout and index codes.
module krps_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output krps_pkg::cfg_t     cfg
);

  logic wr;
  krps_pkg::reg_idx_t idx;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  assign idx = krps_pkg::reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kick_one_step      <= 16'd0;
      cfg.kick_two_step      <= 16'd1000;
      cfg.kick_one_harmonic  <= 4'd1;
      cfg.kick_two_harmonic  <= 4'd3;
      cfg.kick_one_amplitude <= 16'd6554;
      cfg.kick_two_amplitude <= 16'd13107;
      cfg.step_size          <= 16'd6554;
    end else if (wr) begin
      case (idx)
        krps_pkg::REG_K1_STEP: cfg.kick_one_step      <= pwdata[15:0];
        krps_pkg::REG_K2_STEP: cfg.kick_two_step      <= pwdata[15:0];
        krps_pkg::REG_K1_HARM: cfg.kick_one_harmonic  <= pwdata[3:0];
        krps_pkg::REG_K2_HARM: cfg.kick_two_harmonic  <= pwdata[3:0];
        krps_pkg::REG_K1_AMP:  cfg.kick_one_amplitude <= pwdata[15:0];
        krps_pkg::REG_K2_AMP:  cfg.kick_two_amplitude <= pwdata[15:0];
        krps_pkg::REG_DT:      cfg.step_size          <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      krps_pkg::REG_K1_STEP: prdata = {16'd0, cfg.kick_one_step};
      krps_pkg::REG_K2_STEP: prdata = {16'd0, cfg.kick_two_step};
      krps_pkg::REG_K1_HARM: prdata = {28'd0, cfg.kick_one_harmonic};
      krps_pkg::REG_K2_HARM: prdata = {28'd0, cfg.kick_two_harmonic};
      krps_pkg::REG_K1_AMP:  prdata = {16'd0, cfg.kick_one_amplitude};
      krps_pkg::REG_K2_AMP:  prdata = {16'd0, cfg.kick_two_amplitude};
      krps_pkg::REG_DT:      prdata = {16'd0, cfg.step_size};
      default:               prdata = 32'd0;
    endcase
  end

endmodule

>>> src/krps_dp.sv
// Datapath of the kicked rotor phase stepper: particle state, CORDIC sine,
// cube root and divider units, advance and output word. Depends on krps_pkg.
module krps_dp (
  input  logic                   clk,
  input  logic                   rst,
  input  krps_pkg::cfg_t         cfg,
  input  krps_pkg::dp_cmd_t      dp_cmd,
  output krps_pkg::dp_stat_t     stat,
  input  logic [23:0]            theta_init,
  input  logic signed [23:0]     j_init,
  output logic [23:0]            theta_out,
  output logic signed [23:0]     j_out,
  output logic [15:0]            step_index
);

  logic [23:0] phase;
  logic signed [23:0] action;
  logic [23:0] frequency;
  logic [krps_pkg::STEP_BITS-1:0] step_count;

  logic [4:0] iter;
  logic signed [32:0] cx, cy;
  logic signed [25:0] cz;
  logic [19:0] na;
  logic signed [39:0] prod;
  logic signed [47:0] bj;
  logic [63:0] v;
  logic [20:0] r;
  logic [41:0] r2;
  logic [63:0] r3;
  logic [20:0] rem;
  logic [23:0] q;
  logic [39:0] fdt;

  logic [3:0] n;
  logic [15:0] amp;
  logic [27:0] nphase;
  logic signed [23:0] ang;
  logic signed [25:0] zf;
  logic signed [32:0] dx, dy;
  logic signed [18:0] s;
  logic signed [39:0] prod_r;
  logic signed [25:0] jsum;
  logic signed [23:0] jsat;
  logic signed [25:0] u;
  logic [20:0] bitv;
  logic [5:0] iter2;
  logic [63:0] c3;
  logic [63:0] c2;
  logic [39:0] num;
  logic [21:0] rem_s;
  logic [40:0] fdt_r;

  function automatic logic [22:0] atan_turns_w(input logic [4:0] i);
    return krps_pkg::atan_turns(i[3:0]);
  endfunction

  assign n = dp_cmd.kick_sel ? cfg.kick_two_harmonic : cfg.kick_one_harmonic;
  assign amp = dp_cmd.kick_sel ? cfg.kick_two_amplitude : cfg.kick_one_amplitude;
  assign nphase = n * phase;
  assign ang = signed'(nphase[23:0]);

  always_comb begin
    if (ang > 24'sh400000) begin
      zf = 26'sh800000 - 26'(ang);
    end else if (ang < -24'sh400000) begin
      zf = -26'sh800000 - 26'(ang);
    end else begin
      zf = 26'(ang);
    end
  end

  assign dx = cy >>> iter[3:0];
  assign dy = cx >>> iter[3:0];
  assign s = 19'((cy + 33'sd8192) >>> 14);
  assign prod_r = signed'({1'b0, na}) * s;
  assign jsum = 26'(action) + 26'((prod + 40'sd32768) >>> 16);
  assign jsat = (jsum > 26'sd8388607) ? 24'sh7FFFFF :
                (jsum < -26'sd8388608) ? -24'sh800000 : 24'(jsum);
  assign u = 26'sd65536 + 26'((bj + 48'sd8388608) >>> 24);

  assign bitv = 21'(1) << iter;
  assign iter2 = {iter, 1'b0};
  assign c3 = r3 + ((64'(r2) + (64'(r2) << 1)) << iter) +
              ((64'(r) + (64'(r) << 1)) << iter2) + (64'(1) << (iter * 3));
  assign c2 = 64'(r2) + (64'(r) << (iter + 5'd1)) + (64'(1) << iter2);
  assign num = krps_pkg::C_Q43 + 40'(r >> 1);
  assign rem_s = {rem, q[23]};
  assign fdt_r = 41'(fdt) + 41'd32768;

  always_comb begin
    stat.hit_one = krps_pkg::CMP_W'(step_count) == krps_pkg::CMP_W'(cfg.kick_one_step);
    stat.hit_two = krps_pkg::CMP_W'(step_count) == krps_pkg::CMP_W'(cfg.kick_two_step);
    case (dp_cmd.op)
      krps_pkg::OP_CORDIC: stat.last = (iter == krps_pkg::CORDIC_LAST);
      krps_pkg::OP_ROOT:   stat.last = (iter == 5'd0);
      krps_pkg::OP_DIV:    stat.last = (iter == krps_pkg::DIV_LAST);
      default:             stat.last = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= 24'd0;
      action     <= 24'sd0;
      frequency  <= krps_pkg::FREQ_RESET;
      step_count <= '0;
    end else begin
      case (dp_cmd.op)
        krps_pkg::OP_LOAD: begin
          phase      <= theta_init;
          action     <= j_init;
          step_count <= '0;
        end
        krps_pkg::OP_KSAT: action <= jsat;
        krps_pkg::OP_FSET: frequency <= q;
        krps_pkg::OP_AADD: begin
          phase <= phase + fdt_r[39:16];
          if (step_count != '1) begin
            step_count <= step_count + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (dp_cmd.op)
      krps_pkg::OP_KANG: begin
        cx   <= krps_pkg::CORDIC_K;
        cy   <= 33'sd0;
        cz   <= zf;
        na   <= n * amp;
        iter <= 5'd0;
      end
      krps_pkg::OP_CORDIC: begin
        if (cz >= 26'sd0) begin
          cx <= cx - dx;
          cy <= cy + dy;
          cz <= cz - 26'(atan_turns_w(iter));
        end else begin
          cx <= cx + dx;
          cy <= cy - dy;
          cz <= cz + 26'(atan_turns_w(iter));
        end
        iter <= iter + 5'd1;
      end
      krps_pkg::OP_KPROD: prod <= prod_r;
      krps_pkg::OP_FMUL: bj <= action * krps_pkg::B_Q24;
      krps_pkg::OP_RINIT: begin
        v    <= (u < 26'sd256) ? (64'd256 << 41) : (64'(u) << 41);
        r    <= 21'd0;
        r2   <= 42'd0;
        r3   <= 64'd0;
        iter <= krps_pkg::ROOT_MSB;
      end
      krps_pkg::OP_ROOT: begin
        if (c3 <= v) begin
          r  <= r | bitv;
          r2 <= c2[41:0];
          r3 <= c3;
        end
        iter <= iter - 5'd1;
      end
      krps_pkg::OP_DINIT: begin
        rem  <= 21'(num[39:24]);
        q    <= num[23:0];
        iter <= 5'd0;
      end
      krps_pkg::OP_DIV: begin
        if (rem_s >= {1'b0, r}) begin
          rem <= 21'(rem_s - {1'b0, r});
          q   <= {q[22:0], 1'b1};
        end else begin
          rem <= rem_s[20:0];
          q   <= {q[22:0], 1'b0};
        end
        iter <= iter + 5'd1;
      end
      krps_pkg::OP_AMUL: fdt <= frequency * cfg.step_size;
      krps_pkg::OP_OUT: begin
        theta_out  <= phase;
        j_out      <= action;
        step_index <= 16'(step_count);
      end
      default: ;
    endcase
  end

endmodule

>>> src/krps_ctrl.sv
// Controller of the kicked rotor phase stepper: sequences load, kicks,
// frequency update and advance, and owns the input and output handshakes.
// Depends on krps_pkg.
module krps_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   cmd,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  krps_pkg::dp_stat_t     stat,
  output krps_pkg::dp_cmd_t      dp_cmd
);

  krps_pkg::state_t state, state_next;
  logic is_load, is_load_next;
  logic kick_sel, kick_sel_next;
  logic out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= krps_pkg::S_IDLE;
      is_load   <= 1'b0;
      kick_sel  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      is_load   <= is_load_next;
      kick_sel  <= kick_sel_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next    = state;
    is_load_next  = is_load;
    kick_sel_next = kick_sel;
    case (state)
      krps_pkg::S_IDLE: begin
        if (in_valid) begin
          is_load_next = !cmd;
          state_next = cmd ? krps_pkg::S_CHECK : krps_pkg::S_FMUL;
        end
      end
      krps_pkg::S_CHECK: begin
        if (stat.hit_one) begin
          kick_sel_next = 1'b0;
          state_next = krps_pkg::S_KANG;
        end else if (stat.hit_two) begin
          kick_sel_next = 1'b1;
          state_next = krps_pkg::S_KANG;
        end else begin
          state_next = krps_pkg::S_AMUL;
        end
      end
      krps_pkg::S_KANG:   state_next = krps_pkg::S_CORDIC;
      krps_pkg::S_CORDIC: if (stat.last) state_next = krps_pkg::S_KPROD;
      krps_pkg::S_KPROD:  state_next = krps_pkg::S_KSAT;
      krps_pkg::S_KSAT:   state_next = krps_pkg::S_FMUL;
      krps_pkg::S_FMUL:   state_next = krps_pkg::S_RINIT;
      krps_pkg::S_RINIT:  state_next = krps_pkg::S_ROOT;
      krps_pkg::S_ROOT:   if (stat.last) state_next = krps_pkg::S_DINIT;
      krps_pkg::S_DINIT:  state_next = krps_pkg::S_DIV;
      krps_pkg::S_DIV:    if (stat.last) state_next = krps_pkg::S_FSET;
      krps_pkg::S_FSET: begin
        if (is_load) begin
          state_next = krps_pkg::S_DONE;
        end else if (!kick_sel && stat.hit_two) begin
          kick_sel_next = 1'b1;
          state_next = krps_pkg::S_KANG;
        end else begin
          state_next = krps_pkg::S_AMUL;
        end
      end
      krps_pkg::S_AMUL: state_next = krps_pkg::S_AADD;
      krps_pkg::S_AADD: state_next = krps_pkg::S_DONE;
      krps_pkg::S_DONE: if (!out_valid || out_ready) state_next = krps_pkg::S_IDLE;
      default: state_next = krps_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready        = 1'b0;
    dp_cmd.op       = krps_pkg::OP_NONE;
    dp_cmd.kick_sel = kick_sel;
    out_valid_next  = out_valid && !out_ready;
    case (state)
      krps_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && !cmd) dp_cmd.op = krps_pkg::OP_LOAD;
      end
      krps_pkg::S_KANG: begin
        dp_cmd.op = krps_pkg::OP_KANG;
      end
      krps_pkg::S_CORDIC: dp_cmd.op = krps_pkg::OP_CORDIC;
      krps_pkg::S_KPROD:  dp_cmd.op = krps_pkg::OP_KPROD;
      krps_pkg::S_KSAT:   dp_cmd.op = krps_pkg::OP_KSAT;
      krps_pkg::S_FMUL:   dp_cmd.op = krps_pkg::OP_FMUL;
      krps_pkg::S_RINIT:  dp_cmd.op = krps_pkg::OP_RINIT;
      krps_pkg::S_ROOT:   dp_cmd.op = krps_pkg::OP_ROOT;
      krps_pkg::S_DINIT:  dp_cmd.op = krps_pkg::OP_DINIT;
      krps_pkg::S_DIV:    dp_cmd.op = krps_pkg::OP_DIV;
      krps_pkg::S_FSET:   dp_cmd.op = krps_pkg::OP_FSET;
      krps_pkg::S_AMUL:   dp_cmd.op = krps_pkg::OP_AMUL;
      krps_pkg::S_AADD:   dp_cmd.op = krps_pkg::OP_AADD;
      krps_pkg::S_DONE: begin
        if (!out_valid || out_ready) begin
          dp_cmd.op = krps_pkg::OP_OUT;
          out_valid_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == krps_pkg::S_DONE))
    else $error("output word loaded outside the done state");

  a_hold_full_out: assert property (@(posedge clk) disable iff (rst)
    (state == krps_pkg::S_DONE && out_valid && !out_ready) |=> state == krps_pkg::S_DONE)
    else $error("result left done state while output word still held");

  a_load_path: assert property (@(posedge clk) disable iff (rst)
    (state == krps_pkg::S_IDLE && in_valid && !cmd) |=> state == krps_pkg::S_FMUL)
    else $error("load word did not go to the frequency update");

endmodule

>>> src/kicked_rotor_phase_stepper_unit.sv
// Top level of the kicked rotor phase stepper: register file, controller
// and datapath. Depends on krps_pkg, krps_regs, krps_ctrl and krps_dp.
//
// One word is taken at a time and yields one result word. A step with no kick
// runs through check, multiply, add and output from acceptance to result. A load
// takes longer through the 21-iteration cube root and the 24-iteration divider
// that recompute the frequency; each kick adds the 16-iteration CORDIC sine
// and both of those again. The next word is taken as soon as the controller is
// back in idle, while an earlier result may still sit in the output register.
module kicked_rotor_phase_stepper_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               cmd,
  input  logic [23:0]        theta_init,
  input  logic signed [23:0] j_init,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [23:0]        theta_out,
  output logic signed [23:0] j_out,
  output logic [15:0]        step_index,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  krps_pkg::cfg_t     cfg;
  krps_pkg::dp_cmd_t  dp_cmd;
  krps_pkg::dp_stat_t stat;

  krps_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  krps_ctrl u_ctrl (
    .clk, .rst, .in_valid, .cmd, .in_ready, .out_valid, .out_ready, .stat, .dp_cmd
  );

  krps_dp u_dp (
    .clk, .rst, .cfg, .dp_cmd, .stat, .theta_init, .j_init,
    .theta_out, .j_out, .step_index
  );

endmodule

>>> dv/kicked_rotor_phase_stepper_unit_tb.sv
// Testbench for kicked_rotor_phase_stepper_unit: directed table, then random load/step
// streams under several register settings and handshake idling, checked by a predictor.
// Depends on krps_pkg and the kicked_rotor_phase_stepper_unit RTL.
module kicked_rotor_phase_stepper_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam bit CMD_LOAD = 1'b0;
  localparam bit CMD_STEP = 1'b1;
  localparam int REG_NONE = 7;
  localparam longint CYCLE_LIMIT = 400000;
  localparam int SETTLE = 300;
  localparam longint ATAN_TURNS [16] = '{2097152, 1238021, 654136, 332050, 166669, 83416,
    41718, 20860, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

  typedef struct {
    logic [23:0] theta;
    logic [23:0] j;
    logic [15:0] idx;
  } rotor_word_t;

  typedef struct {
    bit          cmd;
    logic [23:0] theta;
    logic [23:0] j;
    bit          typed;
    rotor_word_t res;
  } dir_row_t;

  logic clk, rst;
  logic in_valid, in_ready, cmd;
  logic [23:0] theta_init;
  logic signed [23:0] j_init;
  logic out_valid, out_ready;
  logic [23:0] theta_out;
  logic signed [23:0] j_out;
  logic [15:0] step_index;
  logic psel, penable, pwrite, pready;
  logic [4:0] paddr;
  logic [31:0] pwdata, prdata;

  kicked_rotor_phase_stepper_unit dut (.*);

  krps_pkg::cfg_t cfg_shadow;
  logic [23:0] rot_phase, rot_freq;
  longint      rot_action;
  int          rot_count;
  rotor_word_t pending_words[$];
  int          errors, words_checked, kicks_seen;
  int          send_idle_pct, recv_stall_pct;
  longint      cycles;

  dir_row_t dir_default[8] = '{
    '{CMD_STEP, 24'h0, 24'h0, 1'b0, '{24'h0, 24'h0, 16'h0}},
    '{CMD_LOAD, 24'h0, 24'h0, 1'b1, '{24'h0, 24'h0, 16'd0}},
    '{CMD_STEP, 24'h0, 24'h0, 1'b0, '{24'h0, 24'h0, 16'h0}},
    '{CMD_LOAD, 24'hFFFFFF, 24'h7FFFFF, 1'b1, '{24'hFFFFFF, 24'h7FFFFF, 16'd0}},
    '{CMD_STEP, 24'h0, 24'h0, 1'b0, '{24'h0, 24'h0, 16'h0}},
    '{CMD_LOAD, 24'h400000, 24'h800000, 1'b1, '{24'h400000, 24'h800000, 16'd0}},
    '{CMD_STEP, 24'h0, 24'h0, 1'b0, '{24'h0, 24'h0, 16'h0}},
    '{CMD_STEP, 24'h0, 24'h0, 1'b0, '{24'h0, 24'h0, 16'h0}}
  };

  dir_row_t dir_special[8] = '{
    '{CMD_LOAD, 24'hC00000, 24'hFF0000, 1'b1, '{24'hC00000, 24'hFF0000, 16'd0}},
    '{CMD_STEP, 24'h0, 24'h0, 1'b0, '{24'h0, 24'h0, 16'h0}},
    '{CMD_STEP, 24'h0, 24'h0, 1'b0, '{24'h0, 24'h0, 16'h0}},
    '{CMD_STEP, 24'h0, 24'h0, 1'b0, '{24'h0, 24'h0, 16'h0}},
    '{CMD_LOAD, 24'h123456, 24'h7FFFFF, 1'b1, '{24'h123456, 24'h7FFFFF, 16'd0}},
    '{CMD_STEP, 24'h0, 24'h0, 1'b0, '{24'h0, 24'h0, 16'h0}},
    '{CMD_STEP, 24'h0, 24'h0, 1'b0, '{24'h0, 24'h0, 16'h0}},
    '{CMD_STEP, 24'h0, 24'h0, 1'b0, '{24'h0, 24'h0, 16'h0}}
  };

  function automatic longint rotor_sine(logic [23:0] ang);
    longint z, x, y, dx, dy;
    z = longint'($signed(ang));
    x = 652032874;
    y = 0;
    if (z > 64'sh400000) z = 64'sh800000 - z;
    else if (z < -64'sh400000) z = -64'sh800000 - z;
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_TURNS[i];
      end else begin
        x += dx; y -= dy; z += ATAN_TURNS[i];
      end
    end
    return (y + 8192) >>> 14;
  endfunction

  function automatic logic [23:0] rotation_freq(longint act);
    longint u;
    longint unsigned v, r, c, f;
    u = 65536 + ((act * 7212011 + 64'sh800000) >>> 24);
    if (u < 256) u = 256;
    v = longint'(u) << 41;
    r = 0;
    for (int b = 20; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (c * c * c <= v) r = c;
    end
    f = (64'd989908258285 + r / 2) / r;
    return (f > 64'hFFFFFF) ? 24'hFFFFFF : f[23:0];
  endfunction

  function automatic void apply_kick(logic [3:0] harm, logic [15:0] amp);
    logic [63:0] ang;
    longint s, dj, jn;
    ang = 64'(harm) * 64'(rot_phase);
    s = rotor_sine(ang[23:0]);
    dj = (longint'(harm) * longint'(amp) * s + 32768) >>> 16;
    jn = rot_action + dj;
    if (jn > 8388607) jn = 8388607;
    if (jn < -8388608) jn = -8388608;
    rot_action = jn;
    rot_freq = rotation_freq(rot_action);
    kicks_seen++;
  endfunction

  function automatic rotor_word_t advance_rotor(bit c, logic [23:0] th, logic [23:0] j);
    rotor_word_t w;
    longint unsigned adv;
    if (c == CMD_LOAD) begin
      rot_phase = th;
      rot_action = longint'($signed(j));
      rot_freq = rotation_freq(rot_action);
      rot_count = 0;
    end else begin
      if (rot_count == int'(cfg_shadow.kick_one_step))
        apply_kick(cfg_shadow.kick_one_harmonic, cfg_shadow.kick_one_amplitude);
      if (rot_count == int'(cfg_shadow.kick_two_step))
        apply_kick(cfg_shadow.kick_two_harmonic, cfg_shadow.kick_two_amplitude);
      adv = (64'(rot_freq) * 64'(cfg_shadow.step_size) + 32768) >> 16;
      rot_phase = rot_phase + adv[23:0];
      if (rot_count < (1 << krps_pkg::STEP_BITS) - 1) rot_count++;
    end
    w.theta = rot_phase;
    w.j = rot_action[23:0];
    w.idx = rot_count[15:0];
    return w;
  endfunction

  task automatic report_mismatch(string what, logic [23:0] got, logic [23:0] want);
    $display("mismatch %s: got %h want %h (word %0d)", what, got, want, words_checked);
    errors++;
  endtask

  task automatic send_word(bit c, logic [23:0] th, logic [23:0] j, bit typed = 0,
                           rotor_word_t res = '{24'h0, 24'h0, 16'h0});
    rotor_word_t w;
    logic rdy;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    theta_init <= th;
    j_init <= j;
    do begin
      @(negedge clk);
      rdy = in_ready;
      @(posedge clk);
    end while (!rdy);
    w = advance_rotor(c, th, j);
    pending_words.push_back(typed ? res : w);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    wait (pending_words.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(int idx, logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 5'(idx * 4); pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      krps_pkg::REG_K1_STEP: cfg_shadow.kick_one_step = val[15:0];
      krps_pkg::REG_K2_STEP: cfg_shadow.kick_two_step = val[15:0];
      krps_pkg::REG_K1_HARM: cfg_shadow.kick_one_harmonic = val[3:0];
      krps_pkg::REG_K2_HARM: cfg_shadow.kick_two_harmonic = val[3:0];
      krps_pkg::REG_K1_AMP:  cfg_shadow.kick_one_amplitude = val[15:0];
      krps_pkg::REG_K2_AMP:  cfg_shadow.kick_two_amplitude = val[15:0];
      krps_pkg::REG_DT:      cfg_shadow.step_size = val[15:0];
      default: ;
    endcase
  endtask

  task automatic write_all(logic [15:0] k1s, logic [15:0] k2s, logic [3:0] h1, logic [3:0] h2,
                           logic [15:0] a1, logic [15:0] a2, logic [15:0] dt);
    write_reg(krps_pkg::REG_K1_STEP, {16'($urandom_range(65535)), k1s});
    write_reg(krps_pkg::REG_K2_STEP, {16'($urandom_range(65535)), k2s});
    write_reg(krps_pkg::REG_K1_HARM, {8'($urandom_range(255)), 20'h0, h1});
    write_reg(krps_pkg::REG_K2_HARM, {28'h0, h2});
    write_reg(krps_pkg::REG_K1_AMP, {16'h0, a1});
    write_reg(krps_pkg::REG_K2_AMP, {16'($urandom_range(65535)), a2});
    write_reg(krps_pkg::REG_DT, {16'hFFFF, dt});
  endtask

  task automatic random_config();
    write_all(16'($urandom_range(6)), ($urandom_range(3) == 0) ? 16'($urandom_range(65535))
              : 16'($urandom_range(6)), 4'($urandom_range(15)), 4'($urandom_range(15)),
              16'($urandom_range(65535)), 16'($urandom_range(65535)),
              16'($urandom_range(65535)));
  endtask

  task automatic random_words(int n);
    logic [23:0] th, j;
    for (int i = 0; i < n; i++) begin
      th = 24'($urandom_range(24'hFFFFFF));
      j = 24'($urandom_range(24'hFFFFFF));
      if ($urandom_range(9) == 0) j = {{9{j[23]}}, j[14:0]};
      if ($urandom_range(99) < 15) send_word(CMD_LOAD, th, j);
      else send_word(CMD_STEP, th, j);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
    if (cycles > CYCLE_LIMIT) begin
      $display("kicked_rotor_phase_stepper_unit test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    rotor_word_t w;
    if (!rst && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        report_mismatch("unexpected word theta_out", theta_out, 24'h0);
      end else begin
        w = pending_words.pop_front();
        if (theta_out !== w.theta) report_mismatch("theta_out", theta_out, w.theta);
        if (j_out !== w.j) report_mismatch("j_out", j_out, w.j);
        if (step_index !== w.idx) report_mismatch("step_index", {8'h0, step_index}, {8'h0, w.idx});
        words_checked++;
      end
    end
  end

  initial begin
    rst = 1'b1; in_valid = 1'b0; cmd = 1'b0; theta_init = '0; j_init = '0;
    out_ready = 1'b0; psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    cycles = 0; errors = 0; words_checked = 0; kicks_seen = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    cfg_shadow = '{16'd0, 16'd1000, 4'd1, 4'd3, 16'd6554, 16'd13107, 16'd6554};
    rot_phase = '0; rot_action = 0; rot_count = 0;
    rot_freq = rotation_freq(0);
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_default[i])
      send_word(dir_default[i].cmd, dir_default[i].theta, dir_default[i].j,
                dir_default[i].typed, dir_default[i].res);
    drain();
    // both kicks on one index, first kick with zero harmonic, no advance
    write_all(16'd1, 16'd1, 4'd0, 4'd15, 16'hFFFF, 16'hFFFF, 16'd0);
    write_reg(REG_NONE, 32'hFFFFFFFF);
    foreach (dir_special[i])
      send_word(dir_special[i].cmd, dir_special[i].theta, dir_special[i].j,
                dir_special[i].typed, dir_special[i].res);
    drain();
    write_all(16'd0, 16'hFFFF, 4'd15, 4'd1, 16'd0, 16'd1, 16'hFFFF);
    for (int i = 0; i < 6; i++) send_word(CMD_STEP, 24'h0, 24'h0);
    drain();

    send_idle_pct = 23; recv_stall_pct = 88;
    for (int p = 0; p < 3; p++) begin
      random_config();
      random_words(45);
      drain();
    end
    send_idle_pct = 88; recv_stall_pct = 23;
    for (int p = 0; p < 3; p++) begin
      random_config();
      random_words(45);
      if (p == 1) begin
        in_valid <= 1'b0;
        wait (pending_words.size() == 0);
        @(posedge clk);
        random_words(10);
      end
      drain();
    end
    send_idle_pct = 0; recv_stall_pct = 0;
    random_config();
    random_words(80);
    drain();

    // park the first kick at the top index, second kick early, odd step size
    write_all(16'hFFFF, 16'd2, 4'd5, 4'd2, 16'd40000, 16'd3000, 16'd777);
    send_word(CMD_LOAD, 24'h0ABCDE, 24'hFFC000);
    for (int i = 0; i < 30; i++) send_word(CMD_STEP, 24'h0, 24'h0);
    drain();

    if (pending_words.size() != 0) errors++;
    $display("checked %0d result words, %0d kicks predicted, over default, directed and random registers",
             words_checked, kicks_seen);
    $display("idling swept sender/receiver both ways, with a pause until all results were back");
    if (errors == 0) $display("kicked_rotor_phase_stepper_unit test passed");
    else $display("kicked_rotor_phase_stepper_unit test failed");
    $finish;
  end
endmodule
